FILE: src/bblur_pkg.sv
// shared types, constants and helper functions of the 3x3 box blur
// no dependencies
package bblur_pkg;

  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int SUM_W       = 12;
  localparam int N_W         = 4;
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam int CFG_AW      = 1;
  localparam int CFG_DW      = 13;
  localparam int FW_CFG_W    = 12;
  localparam int FH_CFG_W    = 13;
  localparam int CH_MAX      = 255;

  localparam logic [CFG_AW-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } step_ctl_t;

  // number of neighbors inside the frame
  function automatic logic [N_W-1:0] nbr_count(input step_ctl_t c);
    logic [N_W-1:0] rows;
    logic [N_W-1:0] cols;
    rows = N_W'(1) + N_W'(c.top_ok) + N_W'(c.bot_ok);
    cols = N_W'(1) + N_W'(c.left_ok) + N_W'(c.right_ok);
    return N_W'(rows * cols);
  endfunction

  // ceil(2^16 / n), exact for dividends below 32768
  function automatic logic [RECIP_W-1:0] recip(input logic [N_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd6:    r = 17'd10923;
      4'd9:    r = 17'd7282;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

FILE: src/bblur_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module bblur_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/bblur_front.sv
// front end: config registers, raster counters, classification of transactions
// depends on bblur_pkg
module bblur_front import bblur_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [PIX_W-1:0]       in_tdata,
  input  logic                   in_tuser,
  input  logic                   cfg_we,
  input  logic [CFG_AW-1:0]      cfg_addr,
  input  logic [CFG_DW-1:0]      cfg_wdata,
  input  logic                   q_full,
  output logic                   push,
  output logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] step_addr,
  output pix_t                   step_px,
  output step_ctl_t              step_ctl
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 2);
  localparam int FW_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam int FH_RST = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

  logic [WW-1:0] fw_r, fw_nxt;
  logic [HW-1:0] fh_r, fh_nxt;
  logic [WW-1:0] ic_r, ic_nxt, oc_r, oc_nxt;
  logic [HW-1:0] ir_r, ir_nxt, or_r, or_nxt;
  logic          extra_r, extra_nxt;

  logic complete, emit_now, is_flush, acc, step_go, last_now;

  assign is_flush  = (in_tuser == ACT_FLUSH);
  assign in_tready = !extra_r && !q_full;
  assign acc       = in_tvalid && in_tready;
  assign complete  = (ir_r >= fh_r);
  assign emit_now  = (ir_r > HW'(1)) || ((ir_r == HW'(1)) && (ic_r != '0));
  assign last_now  = emit_now && (or_r == fh_r - HW'(1)) && (oc_r == fw_r - WW'(1));
  assign step_go   = extra_r ? !q_full : (acc && (is_flush ? complete : !complete));
  assign push      = step_go && !cfg_we;

  assign step_addr = ic_r[AW-1:0];

  always_comb begin
    if (extra_r || is_flush) begin
      step_px = '0;
    end else begin
      step_px.red   = in_tdata[CH_W-1:0];
      step_px.green = in_tdata[2*CH_W-1:CH_W];
      step_px.blue  = in_tdata[3*CH_W-1:2*CH_W];
    end
    step_ctl.emit     = emit_now;
    step_ctl.last     = last_now;
    step_ctl.top_ok   = (or_r != '0);
    step_ctl.bot_ok   = (or_r != fh_r - HW'(1));
    step_ctl.left_ok  = (oc_r != '0);
    step_ctl.right_ok = (oc_r != fw_r - WW'(1));
  end

  always_comb begin
    fw_nxt    = fw_r;
    fh_nxt    = fh_r;
    ic_nxt    = ic_r;
    ir_nxt    = ir_r;
    oc_nxt    = oc_r;
    or_nxt    = or_r;
    extra_nxt = extra_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_FRAME_WIDTH: begin
          if (cfg_wdata[FW_CFG_W-1:0] == '0) begin
            fw_nxt = WW'(1);
          end else if (32'(cfg_wdata[FW_CFG_W-1:0]) > 32'(MAX_WIDTH)) begin
            fw_nxt = WW'(MAX_WIDTH);
          end else begin
            fw_nxt = WW'(cfg_wdata[FW_CFG_W-1:0]);
          end
        end
        CFG_FRAME_HEIGHT: begin
          if (cfg_wdata[FH_CFG_W-1:0] == '0) begin
            fh_nxt = HW'(1);
          end else if (32'(cfg_wdata[FH_CFG_W-1:0]) > 32'(MAX_HEIGHT)) begin
            fh_nxt = HW'(MAX_HEIGHT);
          end else begin
            fh_nxt = HW'(cfg_wdata[FH_CFG_W-1:0]);
          end
        end
        default: begin
        end
      endcase
      ic_nxt    = '0;
      ir_nxt    = '0;
      oc_nxt    = '0;
      or_nxt    = '0;
      extra_nxt = 1'b0;
    end else if (step_go) begin
      if (ic_r == fw_r - WW'(1)) begin
        ic_nxt = '0;
        ir_nxt = ir_r + HW'(1);
      end else begin
        ic_nxt = ic_r + WW'(1);
      end
      if (emit_now) begin
        if (oc_r == fw_r - WW'(1)) begin
          oc_nxt = '0;
          or_nxt = or_r + HW'(1);
        end else begin
          oc_nxt = oc_r + WW'(1);
        end
      end
      if (extra_r) begin
        extra_nxt = 1'b0;
      end else if (is_flush && !emit_now) begin
        extra_nxt = 1'b1;
      end
      if (last_now) begin
        ic_nxt = '0;
        ir_nxt = '0;
        oc_nxt = '0;
        or_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r    <= WW'(FW_RST);
      fh_r    <= HW'(FH_RST);
      ic_r    <= '0;
      ir_r    <= '0;
      oc_r    <= '0;
      or_r    <= '0;
      extra_r <= 1'b0;
    end else begin
      fw_r    <= fw_nxt;
      fh_r    <= fh_nxt;
      ic_r    <= ic_nxt;
      ir_r    <= ir_nxt;
      oc_r    <= oc_nxt;
      or_r    <= or_nxt;
      extra_r <= extra_nxt;
    end
  end

  // the second step of a single-row flush always yields a result
  a_extra_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (extra_r && step_go && !cfg_we) |-> emit_now)
    else $error("extra flush step without result");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (ic_r == '0 && ir_r == '0 && oc_r == '0 && !extra_r))
    else $error("config write did not restart frame");

endmodule

FILE: src/bblur_queue.sv
// short fifo of raster steps between front and back end
// no package dependencies
module bblur_queue #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] ent_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != CW'(DEPTH)))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("pop from empty queue");

endmodule

FILE: src/bblur_back.sv
// back end: line stores, 3x3 window, sums, reciprocal divide, output register
// depends on bblur_pkg and bblur_ram
module bblur_back import bblur_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] q_addr,
  input  pix_t                   q_px,
  input  step_ctl_t              q_ctl,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [PIX_W-1:0]       out_tdata,
  output logic                   out_tlast
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic adv;

  logic          s1_valid_r, s1_haz_r;
  logic [AW-1:0] s1_addr_r;
  pix_t          s1_px_r;
  step_ctl_t     s1_ctl_r;

  pix_t          up_rd, mid_rd, top_px;
  pix_t          win_r [3][3];

  logic          s2_valid_r;
  step_ctl_t     s2_ctl_r;

  logic             s3_valid_r, s3_last_r;
  logic [SUM_W-1:0] s3_sr_r, s3_sg_r, s3_sb_r;
  logic [N_W-1:0]   s3_n_r;

  logic              s4_valid_r, s4_last_r;
  logic [PROD_W-1:0] s4_pr_r, s4_pg_r, s4_pb_r;

  logic             out_valid_r, out_last_r;
  pix_t             out_px_r;

  logic [SUM_W-1:0] sr, sg, sb;
  logic [SUM_W-1:0] hr, hg, hb;
  logic [RECIP_W-1:0] rc;

  assign adv   = !out_valid_r || out_tready;
  assign q_pop = adv && !q_empty;

  bblur_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_ram (
    .clk   (clk),
    .we    (q_pop),
    .waddr (q_addr),
    .wdata (q_px),
    .re    (q_pop),
    .raddr (q_addr),
    .rdata (mid_rd)
  );

  bblur_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_up_ram (
    .clk   (clk),
    .we    (adv && s1_valid_r),
    .waddr (s1_addr_r),
    .wdata (mid_rd),
    .re    (q_pop),
    .raddr (q_addr),
    .rdata (up_rd)
  );

  // back-to-back steps on one column: upper write lands after the read
  assign top_px = s1_haz_r ? win_r[1][2] : up_rd;

  always_comb begin
    sr = '0;
    sg = '0;
    sb = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if ((i == 1 || (i == 0 && s2_ctl_r.top_ok) || (i == 2 && s2_ctl_r.bot_ok)) &&
            (j == 1 || (j == 0 && s2_ctl_r.left_ok) || (j == 2 && s2_ctl_r.right_ok))) begin
          sr = sr + SUM_W'(win_r[i][j].red);
          sg = sg + SUM_W'(win_r[i][j].green);
          sb = sb + SUM_W'(win_r[i][j].blue);
        end
      end
    end
  end

  assign hr = s3_sr_r + SUM_W'(s3_n_r >> 1);
  assign hg = s3_sg_r + SUM_W'(s3_n_r >> 1);
  assign hb = s3_sb_r + SUM_W'(s3_n_r >> 1);
  assign rc = recip(s3_n_r);

  function automatic logic [CH_W-1:0] sat(input logic [PROD_W-1:0] p);
    logic [QUOT_W-1:0] q;
    q = p[PROD_W-1:RECIP_SHIFT];
    return (q > QUOT_W'(CH_MAX)) ? CH_W'(CH_MAX) : q[CH_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= q_pop;
      s2_valid_r  <= s1_valid_r && s1_ctl_r.emit;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (q_pop) begin
        s1_addr_r <= q_addr;
        s1_px_r   <= q_px;
        s1_ctl_r  <= q_ctl;
        s1_haz_r  <= s1_valid_r && (s1_addr_r == q_addr);
      end
      if (s1_valid_r) begin
        for (int k = 0; k < 3; k++) begin
          win_r[k][0] <= win_r[k][1];
          win_r[k][1] <= win_r[k][2];
        end
        win_r[0][2] <= top_px;
        win_r[1][2] <= mid_rd;
        win_r[2][2] <= s1_px_r;
        s2_ctl_r    <= s1_ctl_r;
      end
      s3_sr_r   <= sr;
      s3_sg_r   <= sg;
      s3_sb_r   <= sb;
      s3_n_r    <= nbr_count(s2_ctl_r);
      s3_last_r <= s2_ctl_r.last;
      s4_pr_r   <= PROD_W'(hr) * PROD_W'(rc);
      s4_pg_r   <= PROD_W'(hg) * PROD_W'(rc);
      s4_pb_r   <= PROD_W'(hb) * PROD_W'(rc);
      s4_last_r <= s3_last_r;
      if (s4_valid_r) begin
        out_px_r.red   <= sat(s4_pr_r);
        out_px_r.green <= sat(s4_pg_r);
        out_px_r.blue  <= sat(s4_pb_r);
        out_last_r     <= s4_last_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_px_r.blue, out_px_r.green, out_px_r.red};
  assign out_tlast  = out_last_r;

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(s1_valid_r) && $stable(s4_valid_r) && $stable(s1_addr_r)))
    else $error("pipeline moved during stall");

endmodule

FILE: src/box_blur_3x3_edge_aware_core.sv
// 3x3 edge-aware box blur over an rgb raster stream: one pixel per clock sustained
// unless the output stalls. Each result appears frame_width+1 positions after its
// pixel; after the frame, each flush drains one result. A single-row frame's first
// flush makes two line-store steps on one port; all other transactions make one.
// Steps pass from queue via s1, s2, s3, s4 to the output register. The two line
// stores are MAX_WIDTH x 24 simple dual-port rams and need no clearing after reset.
// depends on bblur_pkg, bblur_front, bblur_queue, bblur_back
module box_blur_3x3_edge_aware_core import bblur_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [PIX_W-1:0]  in_tdata,   // red_in, green_in, blue_in
  input  logic              in_tuser,   // action
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [PIX_W-1:0]  out_tdata,  // red_out, green_out, blue_out
  output logic              out_tlast,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int QW = AW + PIX_W + $bits(step_ctl_t);

  logic          push, q_full, q_pop, q_empty;
  logic [AW-1:0] f_addr, q_addr;
  pix_t          f_px, q_px;
  step_ctl_t     f_ctl, q_ctl;
  logic [QW-1:0] q_rdata;

  bblur_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push),
    .step_addr (f_addr),
    .step_px   (f_px),
    .step_ctl  (f_ctl)
  );

  bblur_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata ({f_addr, f_px, f_ctl}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign {q_addr, q_px, q_ctl} = q_rdata;

  bblur_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_addr     (q_addr),
    .q_px       (q_px),
    .q_ctl      (q_ctl),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of box_blur_3x3_edge_aware_core: drives raster frames, flush
// ticks and register writes, and checks every result against a blur predictor inside.
// depends on bblur_pkg and box_blur_3x3_edge_aware_core
module testbench;
  import bblur_pkg::*;

  localparam int LINE_MAX   = 2048;
  localparam int HEIGHT_MAX = 4096;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE     = 12;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } blur_res_t;

  typedef struct {
    logic       act;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    bit         typed;
    blur_res_t  res;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [PIX_W-1:0]  in_tdata = '0;
  logic              in_tuser = ACT_PIXEL;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [PIX_W-1:0]  out_tdata;
  logic              out_tlast;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = CFG_FRAME_WIDTH;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  box_blur_3x3_edge_aware_core u_dut (.*);

  always #5 clk = ~clk;

  // blur predictor state
  int unsigned frame_w, frame_h;
  logic [23:0] upper_line [LINE_MAX];
  logic [23:0] middle_line [LINE_MAX];
  logic [23:0] win [3][3];
  int unsigned in_col, in_row, out_col, out_row;

  blur_res_t pending_q[$];
  int errors = 0;
  int items_done = 0;
  int frames_done = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit in_effect;

  function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic blur_res_t blur_here();
    blur_res_t res;
    int sum_r, sum_g, sum_b, n, rr, cc;
    logic [23:0] px;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      rr = int'(out_row) + dr;
      if (rr < 0 || rr >= int'(frame_h)) continue;
      for (int dc = -1; dc <= 1; dc++) begin
        cc = int'(out_col) + dc;
        if (cc < 0 || cc >= int'(frame_w)) continue;
        px = win[dr + 1][dc + 1];
        sum_r += px[23:16];
        sum_g += px[15:8];
        sum_b += px[7:0];
        n++;
      end
    end
    if (n == 0) n = 1;
    res.red   = 8'(((sum_r + n / 2) / n > 255) ? 255 : (sum_r + n / 2) / n);
    res.green = 8'(((sum_g + n / 2) / n > 255) ? 255 : (sum_g + n / 2) / n);
    res.blue  = 8'(((sum_b + n / 2) / n > 255) ? 255 : (sum_b + n / 2) / n);
    res.last  = (out_row == frame_h - 1 && out_col == frame_w - 1);
    return res;
  endfunction

  // one raster position; returns 1 when a blurred pixel falls out
  function automatic bit raster_step(input logic [23:0] px, output blur_res_t res);
    int unsigned ic;
    logic [23:0] top, mid;
    bit emit;
    ic = (in_col >= LINE_MAX) ? 0 : in_col;
    top = upper_line[ic];
    mid = middle_line[ic];
    upper_line[ic] = mid;
    middle_line[ic] = px;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = px;
    emit = (in_row * frame_w + ic) >= frame_w + 1;
    res = '{default: '0};
    if (emit) begin
      res = blur_here();
      if (out_col + 1 >= frame_w) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col++;
      end
    end
    if (ic + 1 >= frame_w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col = ic + 1;
    end
    return emit;
  endfunction

  function automatic bit predict_blur(input logic act, input logic [23:0] px,
                                      output blur_res_t res);
    bit complete;
    complete = in_row >= frame_h;
    res = '{default: '0};
    in_effect = 1'b0;
    if (act == ACT_PIXEL) begin
      if (complete) return 0;
      in_effect = 1'b1;
      return raster_step(px, res);
    end
    if (!complete) return 0;
    in_effect = 1'b1;
    if (!raster_step(24'h0, res))
      if (!raster_step(24'h0, res)) return 0;
    if (res.last) begin
      restart_frame();
      frames_done++;
    end
    return 1;
  endfunction

  task automatic send_item(input logic act, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input bit typed, input blur_res_t tres);
    blur_res_t res;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {b, g, r};
    do @(posedge clk); while (!in_tready);
    if (predict_blur(act, {r, g, b}, res)) pending_q.push_back(typed ? tres : res);
    if (in_effect) items_done++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) frame_w = clamp_to(int'(val[11:0]), LINE_MAX);
    else frame_h = clamp_to(int'(val), HEIGHT_MAX);
    restart_frame();
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic send_pixel();
    send_item(ACT_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 0, '{default: '0});
  endtask

  task automatic send_flush();
    send_item(ACT_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom), 0, '{default: '0});
  endtask

  // whole or partial frame with noise; a whole frame is then flushed until it drains
  task automatic send_frame(input bit partial);
    int npix;
    npix = partial ? $urandom_range(0, frame_w * frame_h) : frame_w * frame_h;
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(0, 15) == 0) send_flush();
      send_pixel();
    end
    if (partial) return;
    while (in_row >= frame_h) begin
      if ($urandom_range(0, 9) == 0) send_pixel();
      else send_flush();
    end
  endtask

  // receiver stall pattern
  int stall_mode = 0;
  int stall_cnt = 0;
  always @(negedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 9) > 2);
      2: out_tready <= (stall_cnt % 4 != 0);
      default: out_tready <= ($urandom_range(0, 9) > 7);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    blur_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h last %b", out_tdata, out_tlast);
      end else begin
        want = pending_q.pop_front();
        if (out_tdata[7:0] !== want.red || out_tdata[15:8] !== want.green ||
            out_tdata[23:16] !== want.blue || out_tlast !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp r %h g %h b %h last %b, got r %h g %h b %h last %b",
                     want.red, want.green, want.blue, want.last, out_tdata[7:0],
                     out_tdata[15:8], out_tdata[23:16], out_tlast);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  stim_row_t directed [6] = '{
    '{ACT_FLUSH, 8'h00, 8'h00, 8'h00, 0, '{8'h00, 8'h00, 8'h00, 1'b0}},
    '{ACT_PIXEL, 8'hff, 8'h00, 8'hff, 0, '{8'h00, 8'h00, 8'h00, 1'b0}},
    '{ACT_PIXEL, 8'h01, 8'h02, 8'h03, 0, '{8'h00, 8'h00, 8'h00, 1'b0}},
    '{ACT_FLUSH, 8'hff, 8'hff, 8'hff, 1, '{8'hff, 8'h00, 8'hff, 1'b1}},
    '{ACT_PIXEL, 8'h00, 8'hff, 8'h00, 0, '{8'h00, 8'h00, 8'h00, 1'b0}},
    '{ACT_FLUSH, 8'h00, 8'h00, 8'h00, 1, '{8'h00, 8'hff, 8'h00, 1'b1}}
  };

  initial begin
    frame_w = 640;
    frame_h = 480;
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    foreach (win[i, j]) win[i][j] = '0;
    restart_frame();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset geometry, a few pixels, then abandoned
    repeat (4) send_pixel();
    wait_idle();
    cfg_write(CFG_FRAME_WIDTH, 13'd0);
    cfg_write(CFG_FRAME_HEIGHT, 13'd0);
    foreach (directed[i])
      send_item(directed[i].act, directed[i].red, directed[i].green, directed[i].blue,
                directed[i].typed, directed[i].res);
    wait_idle();
    // largest geometry, saturated writes, partial frame
    cfg_write(CFG_FRAME_WIDTH, 13'h1fff);
    cfg_write(CFG_FRAME_HEIGHT, 13'h1fff);
    repeat (6) send_pixel();
    send_flush();
    wait_idle();
    cfg_write(CFG_FRAME_WIDTH, 13'd3);
    cfg_write(CFG_FRAME_HEIGHT, 13'd3);
    send_frame(0);

    while (items_done < 400) begin
      wait_idle();
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0: cfg_write(CFG_FRAME_WIDTH, 13'd1);
          1: cfg_write(CFG_FRAME_WIDTH, 13'd2048);
          2: cfg_write(CFG_FRAME_WIDTH, 13'($urandom_range(8, 40)));
          default: cfg_write(CFG_FRAME_WIDTH, 13'($urandom_range(1, 6)));
        endcase
        if (frame_w > 40) cfg_write(CFG_FRAME_HEIGHT, 13'(4096 + $urandom_range(0, 4095)));
        else if ($urandom_range(0, 5) == 0) cfg_write(CFG_FRAME_HEIGHT, 13'd1);
        else cfg_write(CFG_FRAME_HEIGHT, 13'($urandom_range(1, 6)));
      end
      if (frame_w > 40) begin
        repeat ($urandom_range(1, 20)) send_pixel();
        send_flush();
      end else begin
        send_frame($urandom_range(0, 4) == 0);
      end
    end

    wait_idle();
    repeat (20) @(negedge clk);
    errors += pending_q.size();
    $display("covered %0d effective items, %0d results, %0d frames drained, %0d reg writes",
             items_done, results_seen, frames_done, cfg_writes);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d errors", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
